// ===== src/v3a_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_pkg : shared types, codes and helpers of the vector arithmetic unit
// Fixed point format, action codes, the item carried down the pipeline and
// the rounding / saturation helpers used by front and back end.
// ============================================================================
package v3a_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
    localparam int DVD_WIDTH     = 3 * VALUE_WIDTH;
    localparam int QUO_WIDTH     = VALUE_WIDTH + 1;
    localparam int ROOT_STEPS    = VALUE_WIDTH;

    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_SCALE = 4'd2;
    localparam logic [3:0] ACT_EQUAL = 4'd3;
    localparam logic [3:0] ACT_MAG   = 4'd4;
    localparam logic [3:0] ACT_NORM  = 4'd5;
    localparam logic [3:0] ACT_CROSS = 4'd6;
    localparam logic [3:0] ACT_DOT   = 4'd7;
    localparam logic [3:0] ACT_PROJ  = 4'd8;

    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef logic [VALUE_WIDTH-1:0] t_val;

    // word travelling down the pipeline
    typedef struct packed {
        logic [3:0]                     act;
        logic [2:0][VALUE_WIDTH-1:0]    res;   // finished vector for simple actions
        t_val                           sc;    // finished scalar for dot
        logic                           eq;
        logic                           ovf;
        logic                           dz;
        logic [PROD_WIDTH-1:0]          sq;    // |A|^2
        logic [2:0]                     neg;   // sign of each quotient
        logic [2:0][DVD_WIDTH-1:0]      dvd;   // dividend per lane
        t_val                           root;  // floor sqrt of sq
    } t_item;

    typedef struct packed {
        logic [2:0][QUO_WIDTH-1:0]      quo;
        logic [2:0][PROD_WIDTH-1:0]     rem;
        logic [PROD_WIDTH-1:0]          dsr;
    } t_quo;

    // {overflow, value}: clamp a sign / magnitude pair to the value range
    function automatic logic [VALUE_WIDTH:0] sat_mag(input logic neg,
                                                     input logic [65:0] mag);
        logic [VALUE_WIDTH:0] res;
        if (!neg) begin
            if (mag > 66'(VAL_MAX)) res = {1'b1, VAL_MAX};
            else                    res = {1'b0, mag[VALUE_WIDTH-1:0]};
        end else begin
            if (mag > 66'(VAL_MIN)) res = {1'b1, VAL_MIN};
            else                    res = {1'b0, ~mag[VALUE_WIDTH-1:0] + t_val'(1)};
        end
        return res;
    endfunction

    // round to nearest, ties away from zero, drop the fraction
    function automatic logic [65:0] rnd_shift(input logic [63:0] mag);
        logic [64:0] t;
        t = {1'b0, mag} + (65'd1 << (FRACTION_BITS - 1));
        return {1'b0, t} >> FRACTION_BITS;
    endfunction

    function automatic logic [63:0] abs66(input logic signed [65:0] v);
        logic [65:0] m;
        m = v[65] ? (~v + 66'd1) : v;
        return m[63:0];
    endfunction

endpackage

// ===== src/v3a_ifs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_ifs : word channels of the vector arithmetic unit
// Input channel (operands) and output channel (results), valid / ready.
// ============================================================================
interface v3a_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] factor;

    modport source (output valid, action, first_x, first_y, first_z,
                    second_x, second_y, second_z, factor, input ready);
    modport sink   (input valid, action, first_x, first_y, first_z,
                    second_x, second_y, second_z, factor, output ready);
endinterface

interface v3a_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic signed [31:0] result_scalar;
    logic               equal_flag;
    logic               overflow_flag;
    logic               divide_by_zero;

    modport source (output valid, result_x, result_y, result_z, result_scalar,
                    equal_flag, overflow_flag, divide_by_zero, input ready);
    modport sink   (input valid, result_x, result_y, result_z, result_scalar,
                    equal_flag, overflow_flag, divide_by_zero, output ready);
endinterface

// ===== src/v3a_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_front : products, sums and simple results (5 stages)
// Multiplies, adds, rounds and saturates; prepares dividends for the divider.
// ============================================================================
module v3a_front import v3a_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [31:0] i_factor,
    output logic               o_valid,
    output t_item              o_item
);

    logic signed [31:0] w_a  [3];
    logic signed [31:0] w_b  [3];
    logic signed [31:0] w_ml [6];
    logic signed [31:0] w_mr [6];
    logic signed [32:0] w_sum[3];

    assign w_a[0] = i_first_x;
    assign w_a[1] = i_first_y;
    assign w_a[2] = i_first_z;
    assign w_b[0] = i_second_x;
    assign w_b[1] = i_second_y;
    assign w_b[2] = i_second_z;

    // multiplier operand steering
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_ml[i] = '0;
            w_mr[i] = '0;
        end
        case (i_action)
            ACT_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    w_ml[i] = w_a[i];
                    w_mr[i] = i_factor;
                end
            end
            ACT_CROSS: begin
                w_ml[0] = w_a[1]; w_mr[0] = w_b[2];
                w_ml[1] = w_a[2]; w_mr[1] = w_b[1];
                w_ml[2] = w_a[2]; w_mr[2] = w_b[0];
                w_ml[3] = w_a[0]; w_mr[3] = w_b[2];
                w_ml[4] = w_a[0]; w_mr[4] = w_b[1];
                w_ml[5] = w_a[1]; w_mr[5] = w_b[0];
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    w_ml[i] = w_a[i];
                    w_mr[i] = w_b[i];
                end
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            if (i_action == ACT_SUB) w_sum[i] = 33'(w_a[i]) - 33'(w_b[i]);
            else                     w_sum[i] = 33'(w_a[i]) + 33'(w_b[i]);
        end
    end

    // ---- stage 1: products
    logic               r1_valid;
    logic [3:0]         r1_act;
    logic signed [31:0] r1_a  [3];
    logic signed [31:0] r1_b  [3];
    logic signed [32:0] r1_sum[3];
    logic signed [63:0] r1_sq [3];
    logic signed [63:0] r1_m  [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_act <= i_action;
            for (int i = 0; i < 3; i++) begin
                r1_a[i]   <= w_a[i];
                r1_b[i]   <= w_b[i];
                r1_sum[i] <= w_sum[i];
                r1_sq[i]  <= w_a[i] * w_a[i];
            end
            for (int i = 0; i < 6; i++) r1_m[i] <= w_ml[i] * w_mr[i];
        end
    end

    // ---- stage 2: sums, add / sub / scale results
    logic [31:0]        n2_res [3];
    logic               n2_ovf;
    logic [31:0]        n2_absa[3];
    logic               n2_eq;

    always_comb begin
        logic [32:0] s_as;
        logic [32:0] s_sc;
        logic [63:0] t_abs;
        n2_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s_as = sat_mag(r1_sum[i][32], abs66(66'(r1_sum[i])));
            s_sc = sat_mag(r1_m[i][63], rnd_shift(abs66(66'(r1_m[i]))));
            t_abs = abs66(66'(r1_a[i]));
            n2_absa[i] = t_abs[31:0];
            case (r1_act)
                ACT_ADD, ACT_SUB: begin
                    n2_res[i] = s_as[31:0];
                    n2_ovf    = n2_ovf | s_as[32];
                end
                ACT_SCALE: begin
                    n2_res[i] = s_sc[31:0];
                    n2_ovf    = n2_ovf | s_sc[32];
                end
                default: n2_res[i] = '0;
            endcase
        end
        n2_eq = (r1_act == ACT_EQUAL) && (r1_a[0] == r1_b[0])
                && (r1_a[1] == r1_b[1]) && (r1_a[2] == r1_b[2]);
    end

    logic               r2_valid;
    logic [3:0]         r2_act;
    logic               r2_eq;
    logic [31:0]        r2_res [3];
    logic               r2_ovf;
    logic [63:0]        r2_sq;
    logic signed [65:0] r2_dot;
    logic signed [65:0] r2_crs [3];
    logic [31:0]        r2_absa[3];
    logic               r2_nega[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_act    <= r1_act;
            r2_eq     <= n2_eq;
            r2_ovf    <= n2_ovf;
            r2_sq     <= 64'(r1_sq[0]) + 64'(r1_sq[1]) + 64'(r1_sq[2]);
            r2_dot    <= 66'(r1_m[0]) + 66'(r1_m[1]) + 66'(r1_m[2]);
            r2_crs[0] <= 66'(r1_m[0]) - 66'(r1_m[1]);
            r2_crs[1] <= 66'(r1_m[2]) - 66'(r1_m[3]);
            r2_crs[2] <= 66'(r1_m[4]) - 66'(r1_m[5]);
            for (int i = 0; i < 3; i++) begin
                r2_res[i]  <= n2_res[i];
                r2_absa[i] <= n2_absa[i];
                r2_nega[i] <= r1_a[i][31];
            end
        end
    end

    // ---- stage 3: sign / magnitude split
    logic               r3_valid;
    logic [3:0]         r3_act;
    logic               r3_eq;
    logic [31:0]        r3_res [3];
    logic               r3_ovf;
    logic [63:0]        r3_sq;
    logic               r3_dneg;
    logic [63:0]        r3_dmag;
    logic               r3_cneg[3];
    logic [63:0]        r3_cmag[3];
    logic [31:0]        r3_absa[3];
    logic               r3_nega[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_act  <= r2_act;
            r3_eq   <= r2_eq;
            r3_ovf  <= r2_ovf;
            r3_sq   <= r2_sq;
            r3_dneg <= r2_dot[65];
            r3_dmag <= abs66(r2_dot);
            for (int i = 0; i < 3; i++) begin
                r3_res[i]  <= r2_res[i];
                r3_cneg[i] <= r2_crs[i][65];
                r3_cmag[i] <= abs66(r2_crs[i]);
                r3_absa[i] <= r2_absa[i];
                r3_nega[i] <= r2_nega[i];
            end
        end
    end

    // ---- stage 4: cross / dot rounding, projection partial products
    logic [31:0] n4_res[3];
    logic [31:0] n4_sc;
    logic        n4_ovf;

    always_comb begin
        logic [32:0] s_c;
        logic [32:0] s_d;
        s_d    = sat_mag(r3_dneg, rnd_shift(r3_dmag));
        n4_sc  = '0;
        n4_ovf = r3_ovf;
        for (int i = 0; i < 3; i++) n4_res[i] = r3_res[i];
        case (r3_act)
            ACT_CROSS: begin
                n4_ovf = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    s_c       = sat_mag(r3_cneg[i], rnd_shift(r3_cmag[i]));
                    n4_res[i] = s_c[31:0];
                    n4_ovf    = n4_ovf | s_c[32];
                end
            end
            ACT_DOT: begin
                n4_sc  = s_d[31:0];
                n4_ovf = s_d[32];
            end
            default: ;
        endcase
    end

    logic               r4_valid;
    logic [3:0]         r4_act;
    logic               r4_eq;
    logic [31:0]        r4_res [3];
    logic [31:0]        r4_sc;
    logic               r4_ovf;
    logic [63:0]        r4_sq;
    logic               r4_dneg;
    logic [31:0]        r4_absa[3];
    logic               r4_nega[3];
    logic [63:0]        r4_pplo[3];
    logic [63:0]        r4_pphi[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_act  <= r3_act;
            r4_eq   <= r3_eq;
            r4_sc   <= n4_sc;
            r4_ovf  <= n4_ovf;
            r4_sq   <= r3_sq;
            r4_dneg <= r3_dneg;
            for (int i = 0; i < 3; i++) begin
                r4_res[i]  <= n4_res[i];
                r4_absa[i] <= r3_absa[i];
                r4_nega[i] <= r3_nega[i];
                r4_pplo[i] <= r3_dmag[31:0]  * r3_absa[i];
                r4_pphi[i] <= r3_dmag[63:32] * r3_absa[i];
            end
        end
    end

    // ---- stage 5: dividends and quotient signs
    t_item n5_item;

    always_comb begin
        n5_item      = '0;
        n5_item.act  = r4_act;
        n5_item.sc   = r4_sc;
        n5_item.eq   = r4_eq;
        n5_item.ovf  = r4_ovf;
        n5_item.sq   = r4_sq;
        n5_item.dz   = ((r4_act == ACT_NORM) || (r4_act == ACT_PROJ)) && (r4_sq == '0);
        for (int i = 0; i < 3; i++) begin
            n5_item.res[i] = r4_res[i];
            if (r4_act == ACT_PROJ) begin
                n5_item.dvd[i] = {32'b0, r4_pplo[i]} + {r4_pphi[i], 32'b0};
                n5_item.neg[i] = r4_dneg ^ r4_nega[i];
            end else begin
                n5_item.dvd[i] = {64'b0, r4_absa[i]} << FRACTION_BITS;
                n5_item.neg[i] = r4_nega[i];
            end
        end
    end

    logic  r5_valid;
    t_item r5_item;

    always_ff @(posedge i_clk) begin
        if (i_en) r5_item <= n5_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    assign o_valid = r5_valid;
    assign o_item  = r5_item;

endmodule

// ===== src/v3a_sqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_sqrt : pipelined integer square root of |A|^2
// One result bit per stage, restoring method, 32 stages.
// ============================================================================
module v3a_sqrt import v3a_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic                  r_valid[ROOT_STEPS];
    t_item                 r_item [ROOT_STEPS];
    logic [PROD_WIDTH-1:0] r_rem  [ROOT_STEPS];
    logic [PROD_WIDTH-1:0] r_root [ROOT_STEPS];

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
        logic                  v_in;
        t_item                 it_in;
        logic [PROD_WIDTH-1:0] rem_in;
        logic [PROD_WIDTH-1:0] root_in;
        logic [PROD_WIDTH-1:0] bit_v;
        logic [PROD_WIDTH-1:0] trial;
        logic [PROD_WIDTH-1:0] n_rem;
        logic [PROD_WIDTH-1:0] n_root;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign it_in   = i_item;
            assign rem_in  = i_item.sq;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_valid[g-1];
            assign it_in   = r_item[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        assign bit_v = PROD_WIDTH'(1) << (PROD_WIDTH - 2 - 2 * g);
        assign trial = root_in + bit_v;

        always_comb begin
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = (root_in >> 1) + bit_v;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_valid[g] <= 1'b0;
            else if (i_en) r_valid[g] <= v_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[g] <= it_in;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    always_comb begin
        o_item      = r_item[ROOT_STEPS-1];
        o_item.root = r_root[ROOT_STEPS-1][VALUE_WIDTH-1:0];
    end

    assign o_valid = r_valid[ROOT_STEPS-1];

endmodule

// ===== src/v3a_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_div : three-lane pipelined restoring divider
// One quotient bit per stage, 33 stages; quotient known to fit 33 bits.
// ============================================================================
module v3a_div import v3a_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    output t_quo  o_quo
);

    logic  r_valid[QUO_WIDTH];
    t_item r_item [QUO_WIDTH];
    t_quo  r_quo  [QUO_WIDTH];

    for (genvar g = 0; g < QUO_WIDTH; g++) begin : g_step
        logic  v_in;
        t_item it_in;
        t_quo  q_in;
        t_quo  n_quo;

        if (g == 0) begin : g_first
            always_comb begin
                q_in = '0;
                for (int i = 0; i < 3; i++)
                    q_in.rem[i] = {1'b0, i_item.dvd[i][DVD_WIDTH-1:QUO_WIDTH]};
                if (i_item.act == ACT_NORM) q_in.dsr = {32'b0, i_item.root};
                else                        q_in.dsr = i_item.sq;
            end
            assign v_in  = i_valid;
            assign it_in = i_item;
        end else begin : g_next
            assign v_in  = r_valid[g-1];
            assign it_in = r_item[g-1];
            assign q_in  = r_quo[g-1];
        end

        always_comb begin
            logic [PROD_WIDTH:0] remw;
            logic                ge;
            n_quo = q_in;
            for (int i = 0; i < 3; i++) begin
                remw = {q_in.rem[i], it_in.dvd[i][QUO_WIDTH-1-g]};
                ge   = remw >= {1'b0, q_in.dsr};
                if (ge) n_quo.rem[i] = PROD_WIDTH'(remw - {1'b0, q_in.dsr});
                else    n_quo.rem[i] = remw[PROD_WIDTH-1:0];
                n_quo.quo[i] = {q_in.quo[i][QUO_WIDTH-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_valid[g] <= 1'b0;
            else if (i_en) r_valid[g] <= v_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[g] <= it_in;
                r_quo[g]  <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[QUO_WIDTH-1];
    assign o_item  = r_item[QUO_WIDTH-1];
    assign o_quo   = r_quo[QUO_WIDTH-1];

endmodule

// ===== src/v3a_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_back : quotient rounding, result select and output register
// ============================================================================
module v3a_back import v3a_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_item              i_item,
    input  t_quo               i_quo,
    output logic               o_valid,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic signed [31:0] o_result_z,
    output logic signed [31:0] o_result_scalar,
    output logic               o_equal_flag,
    output logic               o_overflow_flag,
    output logic               o_divide_by_zero
);

    logic [2:0][31:0] n_res;
    logic [31:0]      n_sc;
    logic             n_eq;
    logic             n_ovf;
    logic             n_dz;

    always_comb begin
        logic [2:0][32:0] s_q;
        logic [32:0]      s_m;
        logic             up;
        logic [33:0]      qr;
        for (int i = 0; i < 3; i++) begin
            // nearest, ties up: 2*rem >= divisor
            up     = {i_quo.rem[i], 1'b0} >= {1'b0, i_quo.dsr};
            qr     = {1'b0, i_quo.quo[i]} + 34'(up);
            s_q[i] = sat_mag(i_item.neg[i], 66'(qr));
        end
        s_m   = sat_mag(1'b0, 66'(i_item.root));
        n_res = i_item.res;
        n_sc  = i_item.sc;
        n_eq  = i_item.eq;
        n_ovf = i_item.ovf;
        n_dz  = i_item.dz;
        case (i_item.act)
            ACT_NORM, ACT_PROJ: begin
                if (i_item.dz) begin
                    n_res = '0;
                    n_ovf = 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) n_res[i] = s_q[i][31:0];
                    n_ovf = s_q[0][32] | s_q[1][32] | s_q[2][32];
                end
            end
            ACT_MAG: begin
                n_sc  = s_m[31:0];
                n_ovf = s_m[32];
            end
            default: ;
        endcase
    end

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_valid <= 1'b0;
        else if (i_en) r_valid <= i_valid;
    end

    logic [31:0] r_rx, r_ry, r_rz, r_sc;
    logic        r_eq, r_ovf, r_dz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx  <= n_res[0];
            r_ry  <= n_res[1];
            r_rz  <= n_res[2];
            r_sc  <= n_sc;
            r_eq  <= n_eq;
            r_ovf <= n_ovf;
            r_dz  <= n_dz;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_x       = r_rx;
    assign o_result_y       = r_ry;
    assign o_result_z       = r_rz;
    assign o_result_scalar  = r_sc;
    assign o_equal_flag     = r_eq;
    assign o_overflow_flag  = r_ovf;
    assign o_divide_by_zero = r_dz;

endmodule

// ===== src/vector3_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vector3_arithmetic_unit : Q16.16 three-component vector ALU
// Add, subtract, scale, compare, magnitude, normalize, cross, dot, project.
// ============================================================================
// One word in and one word out per clock while results are taken. Every
// action takes the same path: a 5-stage front end (multipliers, sums,
// rounding), a 32-stage square root pipeline, a 33-stage three-lane
// divider and the output register. Results come out in order. When a
// result sits in the output register and is not taken, the whole pipeline
// holds and the input ready drops in the same cycle; nothing is lost or
// repeated, and gaps on the input just travel as bubbles. Rounding is to
// nearest with ties away from zero, but magnitude is the floor square root;
// all results saturate to the 32-bit range (overflow_flag), and normalize
// or project of a zero first vector gives zeros with divide_by_zero set.
// Unused action codes return an all-zero word.
module vector3_arithmetic_unit import v3a_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    v3a_in_if.sink     i_in,
    v3a_out_if.source  o_out
);

    // global advance: output register empty or being drained
    logic  w_en;
    logic  w_fr_valid, w_sq_valid, w_dv_valid;
    t_item w_fr_item, w_sq_item, w_dv_item;
    t_quo  w_dv_quo;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    v3a_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_action   (i_in.action),
        .i_first_x  (i_in.first_x),
        .i_first_y  (i_in.first_y),
        .i_first_z  (i_in.first_z),
        .i_second_x (i_in.second_x),
        .i_second_y (i_in.second_y),
        .i_second_z (i_in.second_z),
        .i_factor   (i_in.factor),
        .o_valid    (w_fr_valid),
        .o_item     (w_fr_item)
    );

    // floor sqrt of |A|^2: magnitude result and normalize divisor
    v3a_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_item  (w_fr_item),
        .o_valid (w_sq_valid),
        .o_item  (w_sq_item)
    );

    // normalize: |a|<<16 / root ; project: |A.B|*|a| / |A|^2
    v3a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_item  (w_sq_item),
        .o_valid (w_dv_valid),
        .o_item  (w_dv_item),
        .o_quo   (w_dv_quo)
    );

    v3a_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (w_dv_valid),
        .i_item           (w_dv_item),
        .i_quo            (w_dv_quo),
        .o_valid          (o_out.valid),
        .o_result_x       (o_out.result_x),
        .o_result_y       (o_out.result_y),
        .o_result_z       (o_out.result_z),
        .o_result_scalar  (o_out.result_scalar),
        .o_equal_flag     (o_out.equal_flag),
        .o_overflow_flag  (o_out.overflow_flag),
        .o_divide_by_zero (o_out.divide_by_zero)
    );

endmodule

// ===== src/v3a_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// v3a_checker : port-level checks of the vector arithmetic unit
// ============================================================================
module v3a_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_result_x,
    input logic [31:0] i_result_y,
    input logic [31:0] i_result_z,
    input logic [31:0] i_result_scalar,
    input logic        i_equal_flag,
    input logic        i_overflow_flag,
    input logic        i_divide_by_zero
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_x)
            && $stable(i_result_y) && $stable(i_result_z)
            && $stable(i_result_scalar))
        else $error("stalled result changed");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_divide_by_zero |-> i_result_x == 32'd0
            && i_result_y == 32'd0 && i_result_z == 32'd0
            && i_result_scalar == 32'd0 && !i_equal_flag && !i_overflow_flag)
        else $error("divide by zero word not cleared");

    a_eq_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_equal_flag |-> i_result_x == 32'd0
            && i_result_y == 32'd0 && i_result_z == 32'd0
            && i_result_scalar == 32'd0 && !i_overflow_flag)
        else $error("compare word carries data");

    a_scalar_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_scalar != 32'd0 |-> i_result_x == 32'd0
            && i_result_y == 32'd0 && i_result_z == 32'd0)
        else $error("scalar and vector result together");

endmodule

bind vector3_arithmetic_unit v3a_checker u_v3a_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_result_x       (o_out.result_x),
    .i_result_y       (o_out.result_y),
    .i_result_z       (o_out.result_z),
    .i_result_scalar  (o_out.result_scalar),
    .i_equal_flag     (o_out.equal_flag),
    .i_overflow_flag  (o_out.overflow_flag),
    .i_divide_by_zero (o_out.divide_by_zero)
);
